>>> rtl/rpcr_pkg.sv
// Package for the raw pulse capture/replay block: sizes, opcodes and the
// stage/result structs. No dependencies.
`default_nettype none
package rpcr_pkg;

    localparam int STORE_DEPTH = 512;
    localparam int DUR_W       = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);
    localparam int MIN_W       = 16;
    localparam int IDX_W       = 9;
    localparam int OPC_W       = 3;
    localparam int QDEPTH      = 4;
    localparam int QPTR_W      = $clog2(QDEPTH);
    localparam int QCNT_W      = $clog2(QDEPTH + 1);
    localparam int IN_DATA_W   = 16;
    localparam int OUT_DATA_W  = 48;

    localparam logic [MIN_W-1:0] MIN_PULSE_RESET = MIN_W'(150);
    localparam logic [DUR_W-1:0] DUR_MAX         = {DUR_W{1'b1}};

    typedef enum logic [OPC_W-1:0] {
        OP_TICK      = 3'd0,
        OP_CAP_START = 3'd1,
        OP_CAP_STOP  = 3'd2,
        OP_REPLAY    = 3'd3,
        OP_READ      = 3'd4
    } op_t;

    // status captured at the front stage, completed with store data in the following cycle
    typedef struct packed {
        logic             tx_level;
        logic             tx_active;
        logic             capture_on;
        logic [CNT_W-1:0] stored_count;
        logic             read_valid;
    } stage_t;

    // one result beat, last field in the lowest bits
    typedef struct packed {
        logic             read_valid;
        logic [DUR_W-1:0] read_value;
        logic [CNT_W-1:0] stored_count;
        logic             capture_on;
        logic             tx_active;
        logic             tx_level;
    } result_t;

endpackage
`default_nettype wire

>>> rtl/rpcr_store.sv
// Pulse duration store: one write port, two registered read ports.
// Depends on rpcr_pkg.
`default_nettype none
module rpcr_store (
    input  wire logic                        clk,
    input  wire logic                        wr_en,
    input  wire logic [rpcr_pkg::ADDR_W-1:0] wr_addr,
    input  wire logic [rpcr_pkg::DUR_W-1:0]  wr_data,
    input  wire logic [rpcr_pkg::ADDR_W-1:0] rd_a_addr,
    output logic      [rpcr_pkg::DUR_W-1:0]  rd_a_data,
    input  wire logic [rpcr_pkg::ADDR_W-1:0] rd_b_addr,
    output logic      [rpcr_pkg::DUR_W-1:0]  rd_b_data
);

    logic [rpcr_pkg::DUR_W-1:0] mem [rpcr_pkg::STORE_DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_a_data <= mem[rd_a_addr];
        rd_b_data <= mem[rd_b_addr];
    end

endmodule
`default_nettype wire

>>> rtl/rpcr_front.sv
// Front part: accepts items, runs capture/replay control, issues store
// accesses and hands one result per item to the queue. Depends on rpcr_pkg.
`default_nettype none
module rpcr_front (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [rpcr_pkg::MIN_W-1:0]     cfg_data,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [rpcr_pkg::OPC_W-1:0]     opcode,
    input  wire logic                           rx_level,
    input  wire logic [rpcr_pkg::IDX_W-1:0]     read_index,
    input  wire logic                           room,
    output logic                                wr_en,
    output logic      [rpcr_pkg::ADDR_W-1:0]    wr_addr,
    output logic      [rpcr_pkg::DUR_W-1:0]     wr_data,
    output logic      [rpcr_pkg::ADDR_W-1:0]    rd_a_addr,
    output logic      [rpcr_pkg::ADDR_W-1:0]    rd_b_addr,
    input  wire logic [rpcr_pkg::DUR_W-1:0]     rd_a_data,
    input  wire logic [rpcr_pkg::DUR_W-1:0]     rd_b_data,
    output logic                                push_valid,
    output rpcr_pkg::result_t                   push_item
);

    logic [rpcr_pkg::MIN_W-1:0] min_reg;
    logic [rpcr_pkg::CNT_W-1:0] count_reg,   count_next;
    logic [rpcr_pkg::DUR_W-1:0] elapsed_reg, elapsed_next;
    logic                       cap_reg,     cap_next;
    logic                       last_reg,    last_next;
    logic                       act_reg,     act_next;
    logic [rpcr_pkg::CNT_W-1:0] pos_reg,     pos_next;
    logic [rpcr_pkg::DUR_W-1:0] rem_reg,     rem_next;
    logic [rpcr_pkg::DUR_W-1:0] head_reg,    head_next;
    logic                       s1_valid_reg;
    rpcr_pkg::stage_t           s1_reg, s1_next;

    logic                       accept;
    logic [rpcr_pkg::DUR_W-1:0] elapsed_inc;
    logic [rpcr_pkg::CNT_W-1:0] pos_inc;
    rpcr_pkg::op_t              op;

    assign cfg_ready = 1'b1;
    assign in_ready  = room;
    assign accept    = in_valid & room;
    assign op        = rpcr_pkg::op_t'(opcode);
    assign rd_a_addr = rpcr_pkg::ADDR_W'(read_index);
    // rd_b tracks the entry after the replay position
    assign rd_b_addr = rpcr_pkg::ADDR_W'(pos_next + rpcr_pkg::CNT_W'(1));

    always_comb
    begin
        elapsed_inc = (elapsed_reg == rpcr_pkg::DUR_MAX) ? elapsed_reg
                                                          : elapsed_reg + rpcr_pkg::DUR_W'(1);
        pos_inc      = pos_reg + rpcr_pkg::CNT_W'(1);
        count_next   = count_reg;
        elapsed_next = elapsed_reg;
        cap_next     = cap_reg;
        last_next    = last_reg;
        act_next     = act_reg;
        pos_next     = pos_reg;
        rem_next     = rem_reg;
        head_next    = head_reg;
        wr_en        = 1'b0;
        wr_addr      = count_reg[rpcr_pkg::ADDR_W-1:0];
        wr_data      = elapsed_inc;

        if (accept)
        begin
            case (op)
                rpcr_pkg::OP_TICK:
                begin
                    if (act_reg)
                    begin
                        rem_next = rem_reg - rpcr_pkg::DUR_W'(1);
                        if (rem_reg == rpcr_pkg::DUR_W'(1))
                        begin
                            pos_next = pos_inc;
                            if (pos_inc < count_reg)
                            begin
                                rem_next = rd_b_data;
                            end
                            else
                            begin
                                act_next = 1'b0;
                                rem_next = '0;
                            end
                        end
                    end
                    else if (cap_reg)
                    begin
                        elapsed_next = elapsed_inc;
                        if ((rx_level != last_reg)
                            && (count_reg < rpcr_pkg::CNT_W'(rpcr_pkg::STORE_DEPTH))
                            && (elapsed_inc >= rpcr_pkg::DUR_W'(min_reg)))
                        begin
                            wr_en        = 1'b1;
                            count_next   = count_reg + rpcr_pkg::CNT_W'(1);
                            elapsed_next = '0;
                            if (count_reg == '0)
                            begin
                                head_next = elapsed_inc;
                            end
                        end
                    end
                    last_next = rx_level;
                end
                rpcr_pkg::OP_CAP_START:
                begin
                    if (!act_reg)
                    begin
                        count_next   = '0;
                        elapsed_next = '0;
                        cap_next     = 1'b1;
                        last_next    = rx_level;
                    end
                end
                rpcr_pkg::OP_CAP_STOP:
                begin
                    if (!act_reg)
                    begin
                        cap_next = 1'b0;
                    end
                end
                rpcr_pkg::OP_REPLAY:
                begin
                    if (!act_reg)
                    begin
                        cap_next = 1'b0;
                        pos_next = '0;
                        if (count_reg != '0)
                        begin
                            act_next = 1'b1;
                            rem_next = head_reg;
                        end
                        else
                        begin
                            rem_next = '0;
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end

        // replay ticks report the level driven during the tick
        if ((op == rpcr_pkg::OP_TICK) && act_reg)
        begin
            s1_next.tx_level  = ~pos_reg[0];
            s1_next.tx_active = 1'b1;
        end
        else
        begin
            s1_next.tx_level  = act_next & ~pos_next[0];
            s1_next.tx_active = act_next;
        end
        s1_next.capture_on   = cap_next;
        s1_next.stored_count = count_next;
        s1_next.read_valid   = (op == rpcr_pkg::OP_READ)
                               && (rpcr_pkg::CNT_W'(read_index) < count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg      <= rpcr_pkg::MIN_PULSE_RESET;
            count_reg    <= '0;
            elapsed_reg  <= '0;
            cap_reg      <= 1'b0;
            last_reg     <= 1'b0;
            act_reg      <= 1'b0;
            pos_reg      <= '0;
            rem_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                min_reg <= cfg_data;
            end
            count_reg    <= count_next;
            elapsed_reg  <= elapsed_next;
            cap_reg      <= cap_next;
            last_reg     <= last_next;
            act_reg      <= act_next;
            pos_reg      <= pos_next;
            rem_reg      <= rem_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        if (accept)
        begin
            s1_reg <= s1_next;
        end
    end

    assign push_valid             = s1_valid_reg;
    assign push_item.tx_level     = s1_reg.tx_level;
    assign push_item.tx_active    = s1_reg.tx_active;
    assign push_item.capture_on   = s1_reg.capture_on;
    assign push_item.stored_count = s1_reg.stored_count;
    assign push_item.read_valid   = s1_reg.read_valid;
    assign push_item.read_value   = s1_reg.read_valid ? rd_a_data : '0;

endmodule
`default_nettype wire

>>> rtl/rpcr_queue.sv
// Back part: short result queue driving the output stream.
// Depends on rpcr_pkg.
`default_nettype none
module rpcr_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push_valid,
    input  wire rpcr_pkg::result_t push_item,
    output logic                   room,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output rpcr_pkg::result_t      out_item
);

    rpcr_pkg::result_t            fifo [rpcr_pkg::QDEPTH];
    logic [rpcr_pkg::QPTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [rpcr_pkg::QPTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [rpcr_pkg::QCNT_W-1:0]  cnt_reg,    cnt_next;
    logic                         pop;

    assign out_valid = (cnt_reg != '0);
    assign pop       = out_valid & out_ready;
    assign out_item  = fifo[rd_ptr_reg];
    // reserve a slot for the beat already in the front stage
    assign room      = (cnt_reg + rpcr_pkg::QCNT_W'(push_valid))
                       < rpcr_pkg::QCNT_W'(rpcr_pkg::QDEPTH);

    always_comb
    begin
        wr_ptr_next = push_valid ? wr_ptr_reg + rpcr_pkg::QPTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + rpcr_pkg::QPTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg + rpcr_pkg::QCNT_W'(push_valid) - rpcr_pkg::QCNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push_valid)
        begin
            fifo[wr_ptr_reg] <= push_item;
        end
    end

endmodule
`default_nettype wire

>>> rtl/raw_pulse_capture_replay.sv
// Top level of the raw pulse capture/replay block.
// Depends on rpcr_pkg, rpcr_front, rpcr_store, rpcr_queue.
//
// Takes one item (tick or command) per clock, with no gaps, as long as the
// output side keeps up; every item yields exactly one result beat, registered
// in the front stage and then held in the result queue. The rate rests on the
// combinational control update in the front part and the registered reads of
// the 512 x 32 duration store, whose second read port keeps the next replay
// duration ready. A four-beat result queue absorbs output stalls; the input
// stalls only once the queue and the front stage together hold four beats.
// The store needs no clearing after reset. min_pulse_ticks is written on the
// cfg channel, which is always ready.
`default_nettype none
module raw_pulse_capture_replay (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_valid,
    output logic                                   cfg_ready,
    input  wire logic [rpcr_pkg::MIN_W-1:0]        cfg_data,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // opcode[2:0], rx_level[3], read_index[12:4], zero[15:13]
    input  wire logic [rpcr_pkg::IN_DATA_W-1:0]    s_axis_tdata,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // tx_level[0], tx_active[1], capture_on[2], stored_count[12:3],
    // read_value[44:13], read_valid[45], zero[47:46]
    output logic      [rpcr_pkg::OUT_DATA_W-1:0]   m_axis_tdata
);

    localparam int ResW = $bits(rpcr_pkg::result_t);

    logic                          room;
    logic                          wr_en;
    logic [rpcr_pkg::ADDR_W-1:0]   wr_addr;
    logic [rpcr_pkg::DUR_W-1:0]    wr_data;
    logic [rpcr_pkg::ADDR_W-1:0]   rd_a_addr;
    logic [rpcr_pkg::ADDR_W-1:0]   rd_b_addr;
    logic [rpcr_pkg::DUR_W-1:0]    rd_a_data;
    logic [rpcr_pkg::DUR_W-1:0]    rd_b_data;
    logic                          push_valid;
    rpcr_pkg::result_t             push_item;
    rpcr_pkg::result_t             out_item;

    rpcr_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .in_valid   (s_axis_tvalid),
        .in_ready   (s_axis_tready),
        .opcode     (s_axis_tdata[2:0]),
        .rx_level   (s_axis_tdata[3]),
        .read_index (s_axis_tdata[12:4]),
        .room       (room),
        .wr_en      (wr_en),
        .wr_addr    (wr_addr),
        .wr_data    (wr_data),
        .rd_a_addr  (rd_a_addr),
        .rd_b_addr  (rd_b_addr),
        .rd_a_data  (rd_a_data),
        .rd_b_data  (rd_b_data),
        .push_valid (push_valid),
        .push_item  (push_item)
    );

    rpcr_store u_store (
        .clk       (clk),
        .wr_en     (wr_en),
        .wr_addr   (wr_addr),
        .wr_data   (wr_data),
        .rd_a_addr (rd_a_addr),
        .rd_a_data (rd_a_data),
        .rd_b_addr (rd_b_addr),
        .rd_b_data (rd_b_data)
    );

    rpcr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_item  (push_item),
        .room       (room),
        .out_valid  (m_axis_tvalid),
        .out_ready  (m_axis_tready),
        .out_item   (out_item)
    );

    assign m_axis_tdata = {{(rpcr_pkg::OUT_DATA_W - ResW){1'b0}}, out_item};

endmodule
`default_nettype wire

>>> test/raw_pulse_capture_replay_tb.sv
// Self-checking testbench for raw_pulse_capture_replay: directed table, then
// capture/replay sessions with random timing, checked against a local predictor.
// Depends on rpcr_pkg and the RTL top level only.
module raw_pulse_capture_replay_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import rpcr_pkg::*;

    localparam int LIMIT_CYCLES  = 200000;
    localparam int RANDOM_ITEMS  = 1000;
    localparam int DRAIN_CYCLES  = 8;

    localparam logic [OPC_W-1:0] OP_SPARE_A = 3'd5;
    localparam logic [OPC_W-1:0] OP_SPARE_C = 3'd7;

    typedef struct {
        bit                 is_cfg;
        logic [MIN_W-1:0]   cfg_val;
        logic [OPC_W-1:0]   op;
        logic               rx;
        logic [IDX_W-1:0]   idx;
        bit                 typed;
        result_t            want;
    } row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [MIN_W-1:0] cfg_data = '0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [IN_DATA_W-1:0] s_axis_tdata = '0;
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    // predictor state
    logic [DUR_W-1:0] dur_store [STORE_DEPTH];
    logic [CNT_W-1:0] dur_count;
    logic [DUR_W-1:0] since_edge;
    logic             cap_on;
    logic             prev_rx;
    logic             play_on;
    logic [CNT_W-1:0] play_pos;
    logic [DUR_W-1:0] play_left;
    logic [MIN_W-1:0] min_gap;

    result_t pending_status [$];
    row_t    dir_rows [$];
    int      mismatches = 0;
    int      n_sent = 0;
    int      cycles = 0;
    int      send_gap_pct = 0;
    int      recv_stall_pct = 0;

    raw_pulse_capture_replay i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > LIMIT_CYCLES)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("raw_pulse_capture_replay_tb: FAIL");
            $finish;
        end
    end

    always @(negedge clk)
        m_axis_tready <= (recv_stall_pct == 0) || ($urandom_range(99, 0) >= recv_stall_pct);

    // skips zero durations, ends the replay past the last one
    function automatic void load_duration();
        while (play_pos < dur_count)
        begin
            play_left = dur_store[play_pos[ADDR_W-1:0]];
            if (play_left != '0)
                return;
            play_pos++;
        end
        play_on   = 1'b0;
        play_left = '0;
    endfunction

    function automatic result_t advance_capture_replay(input logic [OPC_W-1:0] op,
                                                       input logic rx,
                                                       input logic [IDX_W-1:0] idx);
        result_t r;
        logic    report_after;
        r = '0;
        report_after = 1'b1;
        if (op == OP_TICK)
        begin
            if (play_on)
            begin
                r.tx_level   = ~play_pos[0];
                r.tx_active  = 1'b1;
                report_after = 1'b0;
                if (play_left != '0)
                    play_left--;
                if (play_left == '0)
                begin
                    play_pos++;
                    load_duration();
                end
            end
            else if (cap_on)
            begin
                if (since_edge != DUR_MAX)
                    since_edge++;
                if (rx != prev_rx && dur_count < STORE_DEPTH && since_edge >= min_gap)
                begin
                    dur_store[dur_count[ADDR_W-1:0]] = since_edge;
                    dur_count++;
                    since_edge = '0;
                end
            end
            prev_rx = rx;
        end
        else if (op == OP_READ)
        begin
            if (idx < dur_count)
            begin
                r.read_value = dur_store[idx];
                r.read_valid = 1'b1;
            end
        end
        else if (!play_on)
        begin
            case (op)
                OP_CAP_START:
                begin
                    dur_count  = '0;
                    since_edge = '0;
                    cap_on     = 1'b1;
                    prev_rx    = rx;
                end
                OP_CAP_STOP:
                    cap_on = 1'b0;
                OP_REPLAY:
                begin
                    cap_on   = 1'b0;
                    play_on  = 1'b1;
                    play_pos = '0;
                    load_duration();
                end
                default: ;
            endcase
        end
        if (report_after && play_on)
        begin
            r.tx_level  = ~play_pos[0];
            r.tx_active = 1'b1;
        end
        r.capture_on   = cap_on;
        r.stored_count = dur_count;
        return r;
    endfunction

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s expected %0h got %0h", $time, what, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk)
    begin : result_monitor
        result_t got;
        result_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
            if (pending_status.size() == 0)
            begin
                $display("%0t: result beat expected none got %h", $time, m_axis_tdata);
                mismatches++;
            end
            else
            begin
                want = pending_status.pop_front();
                check_field("tx_level", want.tx_level, got.tx_level);
                check_field("tx_active", want.tx_active, got.tx_active);
                check_field("capture_on", want.capture_on, got.capture_on);
                check_field("stored_count", want.stored_count, got.stored_count);
                check_field("read_value", want.read_value, got.read_value);
                check_field("read_valid", want.read_valid, got.read_valid);
            end
        end
    end

    // entered and left just after a falling edge
    task automatic send_item(input logic [OPC_W-1:0] op, input logic rx,
                             input logic [IDX_W-1:0] idx, input bit typed,
                             input result_t typed_res);
        result_t r;
        while (send_gap_pct != 0 && $urandom_range(99, 0) < send_gap_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, idx, rx, op};
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        r = advance_capture_replay(op, rx, idx);
        pending_status.push_back(typed ? typed_res : r);
        n_sent++;
        @(negedge clk);
    endtask

    task automatic send(input logic [OPC_W-1:0] op, input logic rx,
                        input logic [IDX_W-1:0] idx);
        send_item(op, rx, idx, 1'b0, '0);
    endtask

    task automatic write_min(input logic [MIN_W-1:0] val);
        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= val;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        min_gap = val;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [IDX_W-1:0] pick_index();
        int top;
        top = (dur_count + 1 > STORE_DEPTH - 1) ? STORE_DEPTH - 1 : dur_count + 1;
        if ($urandom_range(1, 0) == 0)
            return IDX_W'($urandom_range(STORE_DEPTH - 1, 0));
        return IDX_W'($urandom_range(top, 0));
    endfunction

    function automatic void add_item(input logic [OPC_W-1:0] op, input logic rx,
                                     input logic [IDX_W-1:0] idx, input bit typed,
                                     input int tx, input int act, input int cap,
                                     input logic [CNT_W-1:0] cnt,
                                     input logic [DUR_W-1:0] rval, input int rvld);
        row_t row;
        row.is_cfg            = 1'b0;
        row.cfg_val           = '0;
        row.op                = op;
        row.rx                = rx;
        row.idx               = idx;
        row.typed             = typed;
        row.want.tx_level     = 1'(tx);
        row.want.tx_active    = 1'(act);
        row.want.capture_on   = 1'(cap);
        row.want.stored_count = cnt;
        row.want.read_value   = rval;
        row.want.read_valid   = 1'(rvld);
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [MIN_W-1:0] val);
        row_t row;
        row         = '{default: '0};
        row.is_cfg  = 1'b1;
        row.cfg_val = val;
        dir_rows.push_back(row);
    endfunction

    task automatic capture_session(input int hold_max, input int n_ticks,
                                   input bit with_noise);
        logic lvl;
        int   hold;
        lvl = 1'($urandom_range(1, 0));
        send(OP_CAP_START, lvl, IDX_W'($urandom_range(STORE_DEPTH - 1, 0)));
        hold = $urandom_range(hold_max, 1);
        for (int t = 0; t < n_ticks; t++)
        begin
            if (with_noise && $urandom_range(29, 0) == 0)
                send(OPC_W'($urandom_range(7, 1)), 1'($urandom_range(1, 0)), pick_index());
            hold--;
            if (hold == 0)
            begin
                lvl  = ~lvl;
                hold = $urandom_range(hold_max, 1);
            end
            send(OP_TICK, lvl, IDX_W'($urandom_range(STORE_DEPTH - 1, 0)));
        end
        if ($urandom_range(1, 0) == 1)
            send(OP_CAP_STOP, 1'($urandom_range(1, 0)), pick_index());
        if (dur_count == STORE_DEPTH)
            send(OP_READ, 1'b0, IDX_W'(STORE_DEPTH - 1));
        repeat ($urandom_range(4, 1))
            send(OP_READ, 1'($urandom_range(1, 0)), pick_index());
        send(OP_REPLAY, 1'($urandom_range(1, 0)), pick_index());
        while (play_on)
        begin
            if ($urandom_range(15, 0) == 0)
                send(OPC_W'($urandom_range(7, 1)), 1'($urandom_range(1, 0)), pick_index());
            send(OP_TICK, 1'($urandom_range(1, 0)), IDX_W'($urandom_range(STORE_DEPTH - 1, 0)));
        end
        repeat ($urandom_range(3, 1))
            send(OP_READ, 1'($urandom_range(1, 0)), pick_index());
    endtask

    task automatic noise_burst();
        repeat (40)
            send(OPC_W'($urandom_range(7, 0)), 1'($urandom_range(1, 0)),
                 IDX_W'($urandom_range(STORE_DEPTH - 1, 0)));
        while (play_on)
            send(OP_TICK, 1'($urandom_range(1, 0)), pick_index());
    endtask

    initial
    begin
        min_gap    = MIN_PULSE_RESET;
        dur_count  = '0;
        since_edge = '0;
        cap_on     = 1'b0;
        prev_rx    = 1'b0;
        play_on    = 1'b0;
        play_pos   = '0;
        play_left  = '0;
        for (int i = 0; i < STORE_DEPTH; i++)
            dur_store[i] = '0;

        // op, rx, idx, typed, tx, act, cap, cnt, rval, rvld
        add_item(OP_TICK,      1'b0, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b1, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_CAP_STOP,  1'b0, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_REPLAY,    1'b0, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_READ,      1'b0, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_READ,      1'b1, 9'd511, 1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_SPARE_A,   1'b1, 9'd511, 1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_SPARE_C,   1'b0, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        // edges shorter than the reset minimum are dropped
        add_item(OP_CAP_START, 1'b1, 9'd0,   1'b1, 0, 0, 1, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b0, 9'd0,   1'b1, 0, 0, 1, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b1, 9'd0,   1'b1, 0, 0, 1, 10'd0, 32'd0, 0);
        add_item(OP_CAP_START, 1'b0, 9'd0,   1'b1, 0, 0, 1, 10'd0, 32'd0, 0);
        add_item(OP_CAP_STOP,  1'b0, 9'd0,   1'b1, 0, 0, 0, 10'd0, 32'd0, 0);
        add_cfg(16'd0);
        add_item(OP_CAP_START, 1'b0, 9'd0,   1'b1, 0, 0, 1, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b1, 9'd0,   1'b1, 0, 0, 1, 10'd1, 32'd0, 0);
        add_item(OP_TICK,      1'b1, 9'd0,   1'b1, 0, 0, 1, 10'd1, 32'd0, 0);
        add_item(OP_TICK,      1'b0, 9'd0,   1'b1, 0, 0, 1, 10'd2, 32'd0, 0);
        add_item(OP_READ,      1'b0, 9'd0,   1'b1, 0, 0, 1, 10'd2, 32'd1, 1);
        add_item(OP_READ,      1'b0, 9'd1,   1'b1, 0, 0, 1, 10'd2, 32'd2, 1);
        add_item(OP_READ,      1'b0, 9'd2,   1'b1, 0, 0, 1, 10'd2, 32'd0, 0);
        add_item(OP_REPLAY,    1'b0, 9'd0,   1'b1, 1, 1, 0, 10'd2, 32'd0, 0);
        // commands other than reads are ignored while replaying
        add_item(OP_CAP_START, 1'b1, 9'd0,   1'b1, 1, 1, 0, 10'd2, 32'd0, 0);
        add_item(OP_TICK,      1'b0, 9'd0,   1'b0, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_READ,      1'b0, 9'd1,   1'b0, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b0, 9'd0,   1'b0, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b0, 9'd0,   1'b0, 0, 0, 0, 10'd0, 32'd0, 0);
        add_item(OP_TICK,      1'b0, 9'd0,   1'b0, 0, 0, 0, 10'd0, 32'd0, 0);

        repeat (3)
            @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (dir_rows[i])
        begin
            if (dir_rows[i].is_cfg)
                write_min(dir_rows[i].cfg_val);
            else
                send_item(dir_rows[i].op, dir_rows[i].rx, dir_rows[i].idx,
                          dir_rows[i].typed, dir_rows[i].want);
        end

        n_sent = 0;
        for (int phase = 0; n_sent < RANDOM_ITEMS || phase < 4; phase++)
        begin
            case (phase % 4)
                0: begin send_gap_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_gap_pct = 47; recv_stall_pct = 0;  end
                2: begin send_gap_pct = 0;  recv_stall_pct = 47; end
                default: begin send_gap_pct = 34; recv_stall_pct = 34; end
            endcase
            if (phase == 0)
                write_min(16'hFFFF);
            else if (phase == 2)
                write_min(16'd0);
            else if ($urandom_range(5, 0) == 0)
                write_min(MIN_W'($urandom_range(65535, 0)));
            else
                write_min(MIN_W'($urandom_range(12, 0)));

            // store fill: an edge on every tick until full, then edges are ignored
            if (phase == 2)
                capture_session(1, STORE_DEPTH + 20, 1'b0);
            else if ($urandom_range(4, 0) == 0)
                noise_burst();
            else
                capture_session((min_gap > 40) ? 40 : min_gap + $urandom_range(15, 1),
                                $urandom_range(80, 20), 1'b1);
        end

        s_axis_tvalid <= 1'b0;
        while (pending_status.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);

        if (mismatches == 0)
            $display("raw_pulse_capture_replay_tb: PASS");
        else
            $display("raw_pulse_capture_replay_tb: FAIL");
        $finish;
    end

endmodule
